/* hdl/ptsp_pkg.sv */
// Shared types and constants for the path table stream parser.
package ptsp_pkg;

  // File layout
  localparam logic [6:0] NAME_BYTES  = 7'd64;
  localparam logic [6:0] WPCNT_LO    = 7'd64;
  localparam logic [6:0] WPCNT_HI    = 7'd65;
  localparam logic [6:0] HDR_LAST    = 7'd67;
  localparam logic [6:0] POINT_LAST  = 7'd7;
  localparam int         NUM_CHUNKS  = 8;
  localparam int         NAME_DEPTH  = 2 * NUM_CHUNKS;
  localparam int         NAME_AW     = $clog2(NAME_DEPTH);

  // Record kinds
  localparam logic [2:0] KIND_START = 3'd0;
  localparam logic [2:0] KIND_CHUNK = 3'd1;
  localparam logic [2:0] KIND_WP    = 3'd2;
  localparam logic [2:0] KIND_PEND  = 3'd3;
  localparam logic [2:0] KIND_TEND  = 3'd4;

  // Register indexes (taken from paddr bit 2)
  localparam logic REG_PATH_LIMIT = 1'b0;
  localparam logic REG_WP_LIMIT   = 1'b1;

  localparam logic [15:0] PATH_LIMIT_RST = 16'd256;
  localparam logic [15:0] WP_LIMIT_RST   = 16'd64;

  // One parse event: everything one input byte asks the emitter to send
  typedef struct packed {
    logic        hdr;
    logic        wp;
    logic        pend;
    logic        tend;
    logic [15:0] path;
    logic [15:0] entry;
    logic [6:0]  nlen;
    logic [15:0] wtot;
    logic [31:0] x;
    logic [31:0] y;
    logic        bank;
    logic [15:0] tcount;
  } ev_t;

  // One output record
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] path;
    logic [15:0] entry;
    logic [6:0]  nlen;
    logic [15:0] wtot;
    logic [63:0] chunk;
    logic [31:0] x;
    logic [31:0] y;
    logic        last;
  } rec_t;

  // Name memory byte write
  typedef struct packed {
    logic               en;
    logic [NAME_AW-1:0] addr;
    logic [2:0]         lane;
    logic [7:0]         data;
  } nm_wr_t;

  // Name memory word read
  typedef struct packed {
    logic               en;
    logic [NAME_AW-1:0] addr;
  } nm_rd_t;

  // Bank release from emitter to parser
  typedef struct packed {
    logic en;
    logic bank;
  } bank_clr_t;

endpackage

/* hdl/ptsp_ifs.sv */
// Valid/ready stream interfaces for the input bytes and the output records.
interface ptsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface ptsp_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         record_kind;
  logic [15:0]        path_index;
  logic [15:0]        entry_index;
  logic [6:0]         name_length;
  logic [15:0]        waypoint_total;
  logic [63:0]        name_chunk;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic               last_of_run;

  modport source (output valid, output record_kind, output path_index, output entry_index,
                  output name_length, output waypoint_total, output name_chunk,
                  output point_x, output point_y, output last_of_run, input ready);
  modport sink   (input valid, input record_kind, input path_index, input entry_index,
                  input name_length, input waypoint_total, input name_chunk,
                  input point_x, input point_y, input last_of_run, output ready);
endinterface

/* hdl/ptsp_name_mem.sv */
// Two-bank name store: byte writes from the parser, registered word reads for the emitter.
module ptsp_name_mem (
  input  logic              clk,
  input  ptsp_pkg::nm_wr_t  wr,
  input  ptsp_pkg::nm_rd_t  rd,
  output logic [63:0]       rd_data_r
);
  import ptsp_pkg::*;

  logic [63:0] name_mem_r [NAME_DEPTH];

  // byte-lane write
  always_ff @(posedge clk) begin
    if (wr.en) begin
      name_mem_r[wr.addr][{wr.lane, 3'b000} +: 8] <= wr.data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= name_mem_r[rd.addr];
    end
  end

endmodule

/* hdl/ptsp_parse.sv */
// Byte parser: tracks file position, writes names to memory, raises parse events.
module ptsp_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_file,
  input  logic [15:0]          path_limit,
  input  logic [15:0]          waypoint_limit,
  input  ptsp_pkg::bank_clr_t  bank_clr,
  output logic                 hold,
  output logic                 push,
  output ptsp_pkg::ev_t        ev,
  output ptsp_pkg::nm_wr_t     wr
);
  import ptsp_pkg::*;

  localparam logic [2:0] PH_COUNT_LO = 3'd0;
  localparam logic [2:0] PH_COUNT_HI = 3'd1;
  localparam logic [2:0] PH_HEADER   = 3'd2;
  localparam logic [2:0] PH_POINTS   = 3'd3;
  localparam logic [2:0] PH_DONE     = 3'd4;

  logic [2:0]  phase_r, phase_nxt;
  logic [6:0]  pos_r, pos_nxt;
  logic [15:0] decl_paths_r, decl_paths_nxt;
  logic [15:0] started_r, started_nxt;
  logic [6:0]  nlen_r, nlen_nxt;
  logic        nend_r, nend_nxt;
  logic [15:0] decl_wp_r, decl_wp_nxt;
  logic [15:0] wp_seen_r, wp_seen_nxt;
  logic [55:0] shift_r, shift_nxt;
  logic [1:0]  busy_r, busy_nxt;

  logic        hdr_done;
  logic [15:0] started_cur;
  logic [15:0] path_cur;
  logic        kept;
  logic [15:0] wp_inc;
  logic [6:0]  nlen_base;
  logic        nend_base;

  // path being parsed after this byte, and whether it gives records
  assign hdr_done    = fire && (phase_r == PH_HEADER) && (pos_r == HDR_LAST);
  assign started_cur = hdr_done ? started_r + 16'd1 : started_r;
  assign path_cur    = started_cur - 16'd1;
  assign kept        = path_cur < path_limit;
  assign wp_inc      = wp_seen_r + 16'd1;
  assign nlen_base   = (pos_r == 7'd0) ? 7'd0 : nlen_r;
  assign nend_base   = (pos_r == 7'd0) ? 1'b0 : nend_r;

  // header bytes wait while their bank still holds unread chunks
  assign hold = (phase_r == PH_HEADER) && busy_r[started_r[0]];

  // next-state and event build
  always_comb begin
    phase_nxt      = phase_r;
    pos_nxt        = pos_r;
    decl_paths_nxt = decl_paths_r;
    started_nxt    = started_r;
    nlen_nxt       = nlen_r;
    nend_nxt       = nend_r;
    decl_wp_nxt    = decl_wp_r;
    wp_seen_nxt    = wp_seen_r;
    shift_nxt      = shift_r;
    ev             = '0;
    wr             = '0;
    ev.path        = path_cur;
    ev.tcount      = (started_cur < path_limit) ? started_cur : path_limit;
    ev.bank        = started_r[0];

    if (fire) begin
      case (phase_r)
        PH_COUNT_LO: begin
          decl_paths_nxt = {8'd0, data_byte};
          phase_nxt      = PH_COUNT_HI;
        end
        PH_COUNT_HI: begin
          decl_paths_nxt = {data_byte, decl_paths_r[7:0]};
          pos_nxt        = 7'd0;
          phase_nxt      = ({data_byte, decl_paths_r[7:0]} != 16'd0) ? PH_HEADER : PH_DONE;
        end
        PH_HEADER: begin
          nlen_nxt = nlen_base;
          nend_nxt = nend_base;
          if (pos_r < NAME_BYTES) begin
            wr.en   = 1'b1;
            wr.addr = {started_r[0], pos_r[5:3]};
            wr.lane = pos_r[2:0];
            if (!nend_base) begin
              if (data_byte == 8'd0) begin
                nend_nxt = 1'b1;
              end else begin
                wr.data  = data_byte;
                nlen_nxt = nlen_base + 7'd1;
              end
            end
          end else if (pos_r == WPCNT_LO) begin
            decl_wp_nxt = {8'd0, data_byte};
          end else if (pos_r == WPCNT_HI) begin
            decl_wp_nxt = {data_byte, decl_wp_r[7:0]};
          end
          if (pos_r == HDR_LAST) begin
            started_nxt = started_cur;
            ev.hdr      = kept;
            ev.nlen     = nlen_r;
            ev.wtot     = decl_wp_r;
            wp_seen_nxt = 16'd0;
            shift_nxt   = '0;
            pos_nxt     = 7'd0;
            if (decl_wp_r == 16'd0) begin
              ev.pend   = kept;
              phase_nxt = (started_cur >= decl_paths_r) ? PH_DONE : PH_HEADER;
            end else begin
              phase_nxt = PH_POINTS;
            end
          end else begin
            pos_nxt = pos_r + 7'd1;
          end
        end
        PH_POINTS: begin
          if (pos_r == POINT_LAST) begin
            if (kept && (wp_seen_r < waypoint_limit)) begin
              ev.wp    = 1'b1;
              ev.entry = wp_seen_r;
              ev.x     = shift_r[31:0];
              ev.y     = {data_byte, shift_r[55:32]};
            end
            wp_seen_nxt = wp_inc;
            shift_nxt   = '0;
            pos_nxt     = 7'd0;
            if (wp_inc >= decl_wp_r) begin
              ev.pend   = kept;
              phase_nxt = (started_r >= decl_paths_r) ? PH_DONE : PH_HEADER;
            end
          end else begin
            shift_nxt[{pos_r[2:0], 3'b000} +: 8] = data_byte;
            pos_nxt = pos_r + 7'd1;
          end
        end
        default: begin
        end
      endcase

      // end of file: close an open kept path, report, start over
      if (end_of_file) begin
        if ((phase_nxt == PH_POINTS) && kept) begin
          ev.pend = 1'b1;
        end
        ev.tend        = 1'b1;
        phase_nxt      = PH_COUNT_LO;
        pos_nxt        = 7'd0;
        decl_paths_nxt = 16'd0;
        started_nxt    = 16'd0;
        nlen_nxt       = 7'd0;
        nend_nxt       = 1'b0;
        decl_wp_nxt    = 16'd0;
        wp_seen_nxt    = 16'd0;
        shift_nxt      = '0;
      end
    end
  end

  assign push = ev.hdr | ev.wp | ev.pend | ev.tend;

  // bank busy from header event until its last chunk is read
  always_comb begin
    busy_nxt = busy_r;
    if (bank_clr.en) begin
      busy_nxt[bank_clr.bank] = 1'b0;
    end
    if (push && ev.hdr) begin
      busy_nxt[started_r[0]] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_COUNT_LO;
      pos_r        <= 7'd0;
      decl_paths_r <= 16'd0;
      started_r    <= 16'd0;
      nlen_r       <= 7'd0;
      nend_r       <= 1'b0;
      decl_wp_r    <= 16'd0;
      wp_seen_r    <= 16'd0;
      shift_r      <= '0;
      busy_r       <= 2'b00;
    end else begin
      phase_r      <= phase_nxt;
      pos_r        <= pos_nxt;
      decl_paths_r <= decl_paths_nxt;
      started_r    <= started_nxt;
      nlen_r       <= nlen_nxt;
      nend_r       <= nend_nxt;
      decl_wp_r    <= decl_wp_nxt;
      wp_seen_r    <= wp_seen_nxt;
      shift_r      <= shift_nxt;
      busy_r       <= busy_nxt;
    end
  end

endmodule

/* hdl/ptsp_evq.sv */
// Small FIFO of parse events between the parser and the emitter.
module ptsp_evq #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ptsp_pkg::ev_t push_data,
  input  logic          pop,
  output ptsp_pkg::ev_t head,
  output logic          not_empty,
  output logic          full
);
  import ptsp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ev_t              q_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign head      = q_r[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == CNT_W'(DEPTH));

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hdl/ptsp_emit.sv */
// Emitter: expands each event into records, reads name chunks, drives the output register.
module ptsp_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  ptsp_pkg::ev_t        q_head,
  output logic                 q_pop,
  output ptsp_pkg::nm_rd_t     rd,
  input  logic [63:0]          rd_data,
  output ptsp_pkg::bank_clr_t  bank_clr,
  output logic                 o_valid_r,
  input  logic                 o_ready,
  output ptsp_pkg::rec_t       o_rec_r
);
  import ptsp_pkg::*;

  ev_t        ev_r;
  logic       ev_valid_r, ev_valid_nxt;
  logic       start_left_r, start_left_nxt;
  logic       chunk_left_r, chunk_left_nxt;
  logic [2:0] chunk_cnt_r, chunk_cnt_nxt;
  logic       wp_left_r, wp_left_nxt;
  logic       pend_left_r, pend_left_nxt;
  logic       tend_left_r, tend_left_nxt;

  rec_t       sel_rec;
  logic       sel_chunk;
  logic       sel_last;
  logic       gen_go;

  logic       p_valid_r;
  rec_t       p_rec_r;
  logic       p_chunk_r;
  logic       o_free;
  logic       p_free;
  rec_t       o_rec_nxt;

  assign o_free = !o_valid_r || o_ready;
  assign p_free = !p_valid_r || o_free;
  assign gen_go = ev_valid_r && p_free;

  // pick the next record of the current event
  always_comb begin
    sel_rec   = '0;
    sel_chunk = 1'b0;
    sel_last  = 1'b0;
    sel_rec.path = ev_r.path;
    if (start_left_r) begin
      sel_rec.kind = KIND_START;
      sel_rec.nlen = ev_r.nlen;
      sel_rec.wtot = ev_r.wtot;
    end else if (chunk_left_r) begin
      sel_rec.kind  = KIND_CHUNK;
      sel_rec.entry = {13'd0, chunk_cnt_r};
      sel_chunk     = 1'b1;
      sel_last      = (chunk_cnt_r == 3'(NUM_CHUNKS - 1)) && !wp_left_r && !pend_left_r
                      && !tend_left_r;
    end else if (wp_left_r) begin
      sel_rec.kind  = KIND_WP;
      sel_rec.entry = ev_r.entry;
      sel_rec.x     = ev_r.x;
      sel_rec.y     = ev_r.y;
      sel_last      = !pend_left_r && !tend_left_r;
    end else if (pend_left_r) begin
      sel_rec.kind = KIND_PEND;
      sel_last     = !tend_left_r;
    end else begin
      sel_rec.kind = KIND_TEND;
      sel_rec.path = ev_r.tcount;
      sel_last     = 1'b1;
    end
    sel_rec.last = sel_last;
  end

  // chunk reads and bank release
  assign rd.en         = gen_go && sel_chunk;
  assign rd.addr       = {ev_r.bank, chunk_cnt_r};
  assign bank_clr.en   = gen_go && sel_chunk && (chunk_cnt_r == 3'(NUM_CHUNKS - 1));
  assign bank_clr.bank = ev_r.bank;

  assign q_pop = q_valid && (!ev_valid_r || (gen_go && sel_last));

  // event sequencing
  always_comb begin
    ev_valid_nxt   = ev_valid_r;
    start_left_nxt = start_left_r;
    chunk_left_nxt = chunk_left_r;
    chunk_cnt_nxt  = chunk_cnt_r;
    wp_left_nxt    = wp_left_r;
    pend_left_nxt  = pend_left_r;
    tend_left_nxt  = tend_left_r;
    if (gen_go) begin
      if (start_left_r) begin
        start_left_nxt = 1'b0;
      end else if (chunk_left_r) begin
        chunk_cnt_nxt = chunk_cnt_r + 3'd1;
        if (chunk_cnt_r == 3'(NUM_CHUNKS - 1)) begin
          chunk_left_nxt = 1'b0;
        end
      end else if (wp_left_r) begin
        wp_left_nxt = 1'b0;
      end else if (pend_left_r) begin
        pend_left_nxt = 1'b0;
      end else begin
        tend_left_nxt = 1'b0;
      end
      if (sel_last) begin
        ev_valid_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      ev_valid_nxt   = 1'b1;
      start_left_nxt = q_head.hdr;
      chunk_left_nxt = q_head.hdr;
      chunk_cnt_nxt  = 3'd0;
      wp_left_nxt    = q_head.wp;
      pend_left_nxt  = q_head.pend;
      tend_left_nxt  = q_head.tend;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r   <= 1'b0;
      start_left_r <= 1'b0;
      chunk_left_r <= 1'b0;
      chunk_cnt_r  <= 3'd0;
      wp_left_r    <= 1'b0;
      pend_left_r  <= 1'b0;
      tend_left_r  <= 1'b0;
    end else begin
      ev_valid_r   <= ev_valid_nxt;
      start_left_r <= start_left_nxt;
      chunk_left_r <= chunk_left_nxt;
      chunk_cnt_r  <= chunk_cnt_nxt;
      wp_left_r    <= wp_left_nxt;
      pend_left_r  <= pend_left_nxt;
      tend_left_r  <= tend_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ev_r <= q_head;
    end
  end

  // record stage, aligned with the name memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (p_free) begin
      p_valid_r <= gen_go;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_go) begin
      p_rec_r   <= sel_rec;
      p_chunk_r <= sel_chunk;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (o_free) begin
      o_valid_r <= p_valid_r;
    end
  end

  // chunk data joins the record from the name memory read
  always_comb begin
    o_rec_nxt       = p_rec_r;
    o_rec_nxt.chunk = p_chunk_r ? rd_data : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (o_free && p_valid_r) begin
      o_rec_r <= o_rec_nxt;
    end
  end

endmodule

/* hdl/path_table_stream_parser.sv */
// Path table stream parser top level: register port, parser, event queue, name memory, emitter.
//
// Takes one file byte per cycle when input is not held, and sends one record per cycle
// while the receiver is ready. Each byte that completes something raises an event
// into an EVQ_DEPTH-entry queue; the emitter turns an event into 1 to 11 records,
// so a header end (path start plus eight name chunks) keeps the output busy while
// later bytes keep flowing. Path names are held in a two-bank name memory, one bank
// per path in turn; the header bytes of a path wait only if the bank they need still
// holds chunks of the path two back that have not been read, and input also waits
// when the queue is full. With the output always ready, a stream of paths is taken at
// one byte per cycle without stalls. Records leave from an output register, behind
// the event queue, the event register and the record stage. No clearing pass after
// reset: the block is ready for bytes as soon as reset is released. Registers: 0x0
// path_limit, 0x4 waypoint_limit.
module path_table_stream_parser #(
  parameter int EVQ_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  ptsp_in_if.sink     in_bus,
  ptsp_out_if.source  out_bus,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ptsp_pkg::*;

  logic [15:0] path_limit_r;
  logic [15:0] wp_limit_r;
  logic        cfg_wr;

  logic        fire;
  logic        hold;
  logic        push;
  ev_t         ev;
  nm_wr_t      nm_wr;
  nm_rd_t      nm_rd;
  logic [63:0] nm_rd_data;
  bank_clr_t   bank_clr;
  logic        q_pop;
  ev_t         q_head;
  logic        q_not_empty;
  logic        q_full;
  rec_t        o_rec;
  logic        o_valid;

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      path_limit_r <= PATH_LIMIT_RST;
      wp_limit_r   <= WP_LIMIT_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_PATH_LIMIT: path_limit_r <= cfg_pwdata[15:0];
        REG_WP_LIMIT:   wp_limit_r   <= cfg_pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_PATH_LIMIT: cfg_prdata = {16'd0, path_limit_r};
      REG_WP_LIMIT:   cfg_prdata = {16'd0, wp_limit_r};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  // input handshake
  assign in_bus.ready = !q_full && !hold;
  assign fire         = in_bus.valid && in_bus.ready;

  ptsp_parse u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (fire),
    .data_byte      (in_bus.data_byte),
    .end_of_file    (in_bus.end_of_file),
    .path_limit     (path_limit_r),
    .waypoint_limit (wp_limit_r),
    .bank_clr       (bank_clr),
    .hold           (hold),
    .push           (push),
    .ev             (ev),
    .wr             (nm_wr)
  );

  ptsp_name_mem u_name_mem (
    .clk       (clk),
    .wr        (nm_wr),
    .rd        (nm_rd),
    .rd_data_r (nm_rd_data)
  );

  ptsp_evq #(
    .DEPTH (EVQ_DEPTH)
  ) u_evq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (ev),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  ptsp_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .rd        (nm_rd),
    .rd_data   (nm_rd_data),
    .bank_clr  (bank_clr),
    .o_valid_r (o_valid),
    .o_ready   (out_bus.ready),
    .o_rec_r   (o_rec)
  );

  // output beat
  assign out_bus.valid          = o_valid;
  assign out_bus.record_kind    = o_rec.kind;
  assign out_bus.path_index     = o_rec.path;
  assign out_bus.entry_index    = o_rec.entry;
  assign out_bus.name_length    = o_rec.nlen;
  assign out_bus.waypoint_total = o_rec.wtot;
  assign out_bus.name_chunk     = o_rec.chunk;
  assign out_bus.point_x        = $signed(o_rec.x);
  assign out_bus.point_y        = $signed(o_rec.y);
  assign out_bus.last_of_run    = o_rec.last;

endmodule

/* hdl/ptsp_chk.sv */
// Port-level checker for the path table stream parser, bound to the top level.
module ptsp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  record_kind,
  input logic [15:0] path_index,
  input logic [15:0] entry_index,
  input logic [63:0] name_chunk,
  input logic        last_of_run
);
  import ptsp_pkg::*;

  // no beat offered right after reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output beat offered after reset");

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(record_kind) && $stable(path_index)
      && $stable(entry_index) && $stable(name_chunk) && $stable(last_of_run))
    else $error("stalled output beat changed");

  // table end always closes its run
  a_tend_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (record_kind == KIND_TEND) |-> last_of_run)
    else $error("table end not last of run");

  // name chunk numbers stay within the name
  a_chunk_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (record_kind == KIND_CHUNK) |-> entry_index < 16'(NUM_CHUNKS))
    else $error("name chunk number out of range");

  // a path start is never the last of its run
  a_start_more: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (record_kind == KIND_START) |-> !last_of_run)
    else $error("path start marked last of run");

endmodule

bind path_table_stream_parser ptsp_chk u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .record_kind (out_bus.record_kind),
  .path_index  (out_bus.path_index),
  .entry_index (out_bus.entry_index),
  .name_chunk  (out_bus.name_chunk),
  .last_of_run (out_bus.last_of_run)
);

/* tb/sv/path_table_stream_parser_tb.sv */
// Self-checking testbench for the path table stream parser: directed files, then random ones.
`timescale 1ns / 1ps

module path_table_stream_parser_tb;
  import ptsp_pkg::*;

  // Watchdog on the run length; the limit leaves a wide margin over the slowest correct run
  localparam int LIMIT_CYCLES = 1_000_000;
  // Cycles allowed for beats that make no record to clear the pipeline
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_FILES = 5;

  // Receiver ready patterns
  localparam int SINK_OPEN    = 0;
  localparam int SINK_RANDOM  = 1;
  localparam int SINK_PATTERN = 2;

  typedef enum logic [2:0] {
    PH_CNT_LO,
    PH_CNT_HI,
    PH_HDR,
    PH_PTS,
    PH_DONE
  } parse_phase_e;

  logic clk = 1'b0;
  logic rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  ptsp_in_if  in_bus ();
  ptsp_out_if out_bus ();

  path_table_stream_parser i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .out_bus    (out_bus),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Parser state mirror
  parse_phase_e p_phase;
  logic [6:0]   p_pos;
  logic [15:0]  p_paths;
  logic [15:0]  p_started;
  logic [7:0]   nm_buf [0:63];
  logic [6:0]   p_nlen;
  logic         p_nm_end;
  logic [15:0]  p_wps;
  logic [15:0]  p_wp_seen;
  logic [63:0]  p_coord;
  logic [15:0]  lim_paths;
  logic [15:0]  lim_wps;
  int           run_cnt;

  rec_t        pending_records [$];
  logic [7:0]  file_q [$];
  int          mism_cnt;
  int          cycle_cnt;
  int          sink_mode;
  int          hold_left;
  bit          src_bursty;
  int          burst_left;

  function automatic void restart_parse();
    p_phase   = PH_CNT_LO;
    p_pos     = '0;
    p_paths   = '0;
    p_started = '0;
    p_nlen    = '0;
    p_nm_end  = 1'b0;
    p_wps     = '0;
    p_wp_seen = '0;
    p_coord   = '0;
    for (int i = 0; i < 64; i++) nm_buf[i] = 8'h00;
  endfunction

  function automatic void add_rec(input logic [2:0] kind, input logic [15:0] path,
                                  input logic [15:0] entry, input logic [6:0] nlen,
                                  input logic [15:0] wtot, input logic [63:0] chunk,
                                  input logic [31:0] x, input logic [31:0] y);
    rec_t r;
    r.kind  = kind;
    r.path  = path;
    r.entry = entry;
    r.nlen  = nlen;
    r.wtot  = wtot;
    r.chunk = chunk;
    r.x     = x;
    r.y     = y;
    r.last  = 1'b0;
    pending_records = {pending_records, r};
    run_cnt++;
  endfunction

  // Current path gets records only below the path limit
  function automatic logic path_kept();
    logic [15:0] cur;
    cur = p_started - 16'd1;
    return cur < lim_paths;
  endfunction

  function automatic void close_path();
    if (path_kept()) add_rec(KIND_PEND, p_started - 16'd1, '0, '0, '0, '0, '0, '0);
    p_pos   = '0;
    p_phase = (p_started >= p_paths) ? PH_DONE : PH_HDR;
  endfunction

  // Work out the records that one accepted beat causes
  task automatic parse_byte(input logic [7:0] b, input logic eof);
    logic [6:0]  pos;
    logic [63:0] chunk;
    rec_t        r;
    pos = p_pos;
    run_cnt = 0;
    case (p_phase)
      PH_CNT_LO: begin
        p_paths = {8'h00, b};
        p_phase = PH_CNT_HI;
      end
      PH_CNT_HI: begin
        p_paths[15:8] = b;
        p_pos = '0;
        p_phase = (p_paths != 16'd0) ? PH_HDR : PH_DONE;
      end
      PH_HDR: begin
        if (pos == 7'd0) begin
          p_nlen = '0;
          p_nm_end = 1'b0;
        end
        if (pos < NAME_BYTES) begin
          // name bytes from the first zero on are stored as zero
          if (p_nm_end || b == 8'h00) begin
            p_nm_end = 1'b1;
            nm_buf[pos[5:0]] = 8'h00;
          end else begin
            nm_buf[pos[5:0]] = b;
            p_nlen++;
          end
        end else if (pos == WPCNT_LO) begin
          p_wps = {8'h00, b};
        end else if (pos == WPCNT_HI) begin
          p_wps[15:8] = b;
        end
        if (pos >= HDR_LAST) begin
          p_started++;
          if (path_kept()) begin
            add_rec(KIND_START, p_started - 16'd1, '0, p_nlen, p_wps, '0, '0, '0);
            for (int k = 0; k < NUM_CHUNKS; k++) begin
              for (int j = 0; j < 8; j++) chunk[8*j +: 8] = nm_buf[8*k + j];
              add_rec(KIND_CHUNK, p_started - 16'd1, 16'(k), '0, '0, chunk, '0, '0);
            end
          end
          p_wp_seen = '0;
          p_coord = '0;
          p_pos = '0;
          if (p_wps == 16'd0) close_path();
          else p_phase = PH_PTS;
        end else begin
          p_pos = pos + 7'd1;
        end
      end
      PH_PTS: begin
        p_coord[pos[2:0]*8 +: 8] = b;
        if (pos >= POINT_LAST) begin
          if (path_kept() && p_wp_seen < lim_wps)
            add_rec(KIND_WP, p_started - 16'd1, p_wp_seen, '0, '0, '0,
                    p_coord[31:0], p_coord[63:32]);
          p_wp_seen++;
          p_coord = '0;
          p_pos = '0;
          if (p_wp_seen >= p_wps) close_path();
        end else begin
          p_pos = pos + 7'd1;
        end
      end
      default: ;
    endcase
    // End of file closes an open waypoint list and reports the kept paths
    if (eof) begin
      if (p_phase == PH_PTS && path_kept())
        add_rec(KIND_PEND, p_started - 16'd1, '0, '0, '0, '0, '0, '0);
      add_rec(KIND_TEND, (p_started < lim_paths) ? p_started : lim_paths,
              '0, '0, '0, '0, '0, '0);
      restart_parse();
    end
    if (run_cnt > 0) begin
      r = pending_records.pop_back();
      r.last = 1'b1;
      pending_records = {pending_records, r};
    end
  endtask

  task automatic check_field(input string fname, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      mism_cnt++;
    end
  endtask

  // Compare each record beat against the oldest expectation
  always @(posedge clk) begin
    rec_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_records.size() == 0) begin
        $display("%0t: unexpected record, expected none, actual kind %0d path %0d",
                 $time, out_bus.record_kind, out_bus.path_index);
        mism_cnt++;
      end else begin
        want = pending_records.pop_front();
        check_field("record_kind", 64'(want.kind), 64'(out_bus.record_kind));
        check_field("path_index", 64'(want.path), 64'(out_bus.path_index));
        check_field("entry_index", 64'(want.entry), 64'(out_bus.entry_index));
        check_field("name_length", 64'(want.nlen), 64'(out_bus.name_length));
        check_field("waypoint_total", 64'(want.wtot), 64'(out_bus.waypoint_total));
        check_field("name_chunk", want.chunk, out_bus.name_chunk);
        check_field("point_x", {32'd0, want.x}, {32'd0, out_bus.point_x});
        check_field("point_y", {32'd0, want.y}, {32'd0, out_bus.point_y});
        check_field("last_of_run", 64'(want.last), 64'(out_bus.last_of_run));
      end
    end
  end

  // Receiver: long hold-off when asked, else the selected ready pattern
  initial begin
    int tick;
    tick = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        case (sink_mode)
          SINK_OPEN:   out_bus.ready <= 1'b1;
          SINK_RANDOM: out_bus.ready <= ($urandom_range(0, 99) < 60);
          default:     out_bus.ready <= ((tick % 9) < 6) && ((tick % 37) != 0);
        endcase
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  // Send one beat, with random bursts and gaps when enabled
  task automatic send_byte(input logic [7:0] b, input logic eof);
    int gap;
    if (src_bursty) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 32);
        gap = $urandom_range(1, 8);
        @(negedge clk);
        in_bus.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left--;
    end
    @(negedge clk);
    in_bus.valid       <= 1'b1;
    in_bus.data_byte   <= b;
    in_bus.end_of_file <= eof;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    parse_byte(b, eof);
  endtask

  task automatic send_file(input logic close);
    for (int i = 0; i < file_q.size(); i++)
      send_byte(file_q[i], close && (i == file_q.size() - 1));
    file_q.delete();
  endtask

  // Stop sending, then wait until every record is out and the pipe is empty
  task automatic settle();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] v);
    logic [15:0] junk;
    junk = 16'($urandom);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {junk, v};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (idx == REG_PATH_LIMIT) lim_paths = v;
    else lim_wps = v;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Append one byte to the file being built
  task automatic put_byte(input logic [7:0] b);
    file_q = {file_q, b};
  endtask

  task automatic put_u16(input logic [15:0] v);
    put_byte(v[7:0]);
    put_byte(v[15:8]);
  endtask

  task automatic put_point(input logic [31:0] x, input logic [31:0] y);
    for (int i = 0; i < 4; i++) put_byte(x[8*i +: 8]);
    for (int i = 0; i < 4; i++) put_byte(y[8*i +: 8]);
  endtask

  // Header: nlen name characters (fill, or random nonzero), a zero if nlen < 64, random tail
  task automatic put_header(input int nlen, input logic [7:0] fill, input logic [15:0] wps);
    logic [7:0] r;
    for (int i = 0; i < 64; i++) begin
      if (i < nlen) r = (fill != 8'h00) ? fill : 8'($urandom_range(1, 255));
      else if (i == nlen) r = 8'h00;
      else r = 8'($urandom);
      put_byte(r);
    end
    put_u16(wps);
    r = 8'($urandom);
    put_byte(r);
    r = 8'($urandom);
    put_byte(r);
  endtask

  task automatic test_short_files();
    sink_mode = SINK_OPEN;
    src_bursty = 1'b0;
    // one-byte file
    put_byte(8'h5A);
    send_file(1'b1);
    // path count of one, file ends before the header
    put_byte(8'h01);
    put_byte(8'h00);
    send_file(1'b1);
    // zero path count, the rest ignored
    put_u16(16'h0000);
    put_byte(8'h13);
    put_byte(8'hFF);
    send_file(1'b1);
  endtask

  task automatic test_path_layout();
    sink_mode = SINK_RANDOM;
    src_bursty = 1'b1;
    put_u16(16'd3);
    put_header(64, 8'hFF, 16'd2);
    put_point(32'h8000_0000, 32'h7FFF_FFFF);
    put_point(32'hFFFF_FFFF, 32'h0000_0000);
    // empty name, no waypoints
    put_header(0, 8'h00, 16'd0);
    put_header(7, 8'h01, 16'd1);
    put_point(32'h7FFF_FFFF, 32'h8000_0000);
    // bytes past the declared paths
    put_byte(8'hA5);
    put_byte(8'h00);
    put_byte(8'hFF);
    send_file(1'b1);
  endtask

  task automatic test_truncated_files();
    sink_mode = SINK_PATTERN;
    src_bursty = 1'b1;
    // second header cut short: that path is dropped
    put_u16(16'd2);
    put_header(10, 8'h00, 16'd1);
    put_point($urandom, $urandom);
    repeat (30) put_byte(8'($urandom));
    send_file(1'b1);
    // waypoint list cut inside a waypoint: path end still given
    put_u16(16'd1);
    put_header(5, 8'h00, 16'hFFFF);
    put_point($urandom, $urandom);
    put_point($urandom, $urandom);
    repeat (3) put_byte(8'($urandom));
    send_file(1'b1);
  endtask

  task automatic test_limits();
    sink_mode = SINK_RANDOM;
    src_bursty = 1'b0;
    settle();
    write_reg(REG_PATH_LIMIT, 16'd1);
    write_reg(REG_WP_LIMIT, 16'd1);
    put_u16(16'd3);
    repeat (3) begin
      put_header($urandom_range(0, 64), 8'h00, 16'd3);
      repeat (3) put_point($urandom, $urandom);
    end
    send_file(1'b1);
    settle();
    write_reg(REG_PATH_LIMIT, 16'd0);
    write_reg(REG_WP_LIMIT, 16'hFFFF);
    put_u16(16'd2);
    repeat (2) begin
      put_header(12, 8'h00, 16'd2);
      repeat (2) put_point($urandom, $urandom);
    end
    send_file(1'b1);
    settle();
    write_reg(REG_PATH_LIMIT, 16'hFFFF);
    write_reg(REG_WP_LIMIT, 16'd0);
    put_u16(16'd2);
    repeat (2) begin
      put_header(33, 8'h00, 16'd2);
      repeat (2) put_point($urandom, $urandom);
    end
    send_file(1'b1);
    settle();
    write_reg(REG_PATH_LIMIT, PATH_LIMIT_RST);
    write_reg(REG_WP_LIMIT, WP_LIMIT_RST);
  endtask

  // Limit changed between a header and its waypoints
  task automatic test_midstream_config();
    sink_mode = SINK_OPEN;
    src_bursty = 1'b1;
    settle();
    write_reg(REG_PATH_LIMIT, 16'd0);
    put_u16(16'd1);
    put_header(20, 8'h00, 16'd2);
    send_file(1'b0);
    settle();
    write_reg(REG_PATH_LIMIT, 16'd1);
    // waypoints and path end without a start
    repeat (2) put_point($urandom, $urandom);
    put_byte(8'h7E);
    send_file(1'b1);
    settle();
    put_u16(16'd1);
    put_header(40, 8'h00, 16'd2);
    send_file(1'b0);
    settle();
    write_reg(REG_PATH_LIMIT, 16'd0);
    // start and name chunks given, then no waypoints or path end
    repeat (2) put_point($urandom, $urandom);
    send_file(1'b1);
    settle();
    write_reg(REG_PATH_LIMIT, PATH_LIMIT_RST);
  endtask

  // Receiver holds off while the sender keeps offering beats
  task automatic test_backpressure();
    sink_mode = SINK_OPEN;
    src_bursty = 1'b0;
    settle();
    put_u16(16'd4);
    repeat (4) begin
      put_header($urandom_range(0, 64), 8'h00, 16'd2);
      repeat (2) put_point($urandom, $urandom);
    end
    hold_left = 300;
    send_file(1'b1);
  endtask

  task automatic build_random_file();
    int          shape;
    int          n_put;
    int          nlen;
    int          wp_decl;
    int          wp_sent;
    int          cut;
    logic [15:0] cnt;
    shape = $urandom_range(0, 9);
    // plain noise
    if (shape == 0) begin
      repeat ($urandom_range(1, 24)) put_byte(8'($urandom));
      return;
    end
    case ($urandom_range(0, 7))
      0:       cnt = 16'd0;
      1:       cnt = 16'($urandom);
      default: cnt = 16'($urandom_range(1, 4));
    endcase
    put_u16(cnt);
    n_put = (cnt > 16'd4) ? $urandom_range(0, 3) : int'(cnt);
    for (int p = 0; p < n_put; p++) begin
      case ($urandom_range(0, 5))
        0:       nlen = 0;
        1:       nlen = 64;
        2:       nlen = 63;
        default: nlen = $urandom_range(1, 64);
      endcase
      wp_decl = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 65535) : $urandom_range(0, 5);
      put_header(nlen, 8'h00, 16'(wp_decl));
      wp_sent = (wp_decl > 5) ? $urandom_range(0, 6) : wp_decl;
      repeat (wp_sent) put_point($urandom, $urandom);
      // file ends inside the waypoint list
      if (wp_sent < wp_decl) break;
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 12)) put_byte(8'($urandom));
    if (shape == 1 && file_q.size() > 1) begin
      cut = $urandom_range(1, file_q.size() - 1);
      while (file_q.size() > cut) void'(file_q.pop_back());
    end
  endtask

  task automatic test_random_files();
    logic [15:0] v;
    for (int f = 0; f < RANDOM_FILES; f++) begin
      // new limits and idling every few files
      if (f % 5 == 0) begin
        settle();
        case ($urandom_range(0, 5))
          0:       v = 16'd0;
          1:       v = 16'd1;
          2:       v = 16'd2;
          3:       v = 16'hFFFF;
          4:       v = PATH_LIMIT_RST;
          default: v = 16'($urandom);
        endcase
        write_reg(REG_PATH_LIMIT, v);
        case ($urandom_range(0, 4))
          0:       v = 16'd0;
          1:       v = 16'd1;
          2:       v = 16'd3;
          3:       v = 16'hFFFF;
          default: v = 16'($urandom);
        endcase
        write_reg(REG_WP_LIMIT, v);
        sink_mode = $urandom_range(SINK_OPEN, SINK_PATTERN);
        src_bursty = 1'($urandom_range(0, 1));
      end
      build_random_file();
      send_file(1'b1);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.data_byte = 8'h00;
    in_bus.end_of_file = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    lim_paths = PATH_LIMIT_RST;
    lim_wps = WP_LIMIT_RST;
    mism_cnt = 0;
    sink_mode = SINK_OPEN;
    hold_left = 0;
    src_bursty = 1'b0;
    burst_left = 0;
    restart_parse();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_short_files();
    test_path_layout();
    test_truncated_files();
    test_limits();
    test_midstream_config();
    test_backpressure();
    test_random_files();
    settle();

    if (mism_cnt == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

/* filelist.f */
hdl/ptsp_pkg.sv
hdl/ptsp_ifs.sv
hdl/ptsp_name_mem.sv
hdl/ptsp_parse.sv
hdl/ptsp_evq.sv
hdl/ptsp_emit.sv
hdl/path_table_stream_parser.sv
hdl/ptsp_chk.sv
tb/sv/path_table_stream_parser_tb.sv
